>>> hw/rtl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/bole_pkg.sv
`timescale 1ns / 1ps

package bole_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ACT_W    = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 5;
  localparam int ST_W     = 3;
  localparam int LEN_W    = 5;
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_HEAD = 3'd0,
    ACT_INS_TAIL = 3'd1,
    ACT_INS_POS  = 3'd2,
    ACT_DEL_POS  = 3'd3,
    ACT_SEARCH   = 3'd4
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] found_position;
    logic [LEN_W-1:0] length;
  } rsp_t;

endpackage

>>> hw/rtl/bole_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bole_core
  import bole_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  input  req_t req,
  output logic idle,
  output logic rsp_valid,
  output rsp_t rsp,
  input  logic rsp_ready
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_OPEN   = 5'b00010,
    S_CLOSE  = 5'b00100,
    S_SEARCH = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        ptr_r, ptr_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    pend_r, pend_nxt;
  logic [IDX_W-1:0]        pend_addr_r, pend_addr_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  status_t                 status_r, status_nxt;
  logic [LEN_W-1:0]        found_r, found_nxt;

  logic [VAL_W-1:0]        mem [CAPACITY];
  logic [VAL_W-1:0]        rd_data_r;
  logic                    rd_en, wr_en;
  logic [IDX_W-1:0]        rd_addr, wr_addr;
  logic [VAL_W-1:0]        wr_data;

  logic [CMP_W-1:0]        pos_ext, cnt_ext;
  logic [CNT_W-1:0]        ptr_inc;
  logic                    match;

  assign pos_ext = CMP_W'(req.position);
  assign cnt_ext = CMP_W'(count_r);
  assign ptr_inc = ptr_r + CNT_W'(1);
  // shared comparator for search
  assign match   = (rd_data_r == value_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    value_nxt     = value_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          value_nxt  = req.value;
          pend_nxt   = 1'b0;
          found_nxt  = '0;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (req.action) inside
            ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
              if (count_r >= CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else if (req.action == ACT_INS_POS &&
                           (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))) begin
                status_nxt = ST_BADPOS;
              end else begin
                if (req.action == ACT_INS_HEAD) begin
                  idx_nxt = '0;
                end else if (req.action == ACT_INS_TAIL) begin
                  idx_nxt = count_r[IDX_W-1:0];
                end else begin
                  idx_nxt = IDX_W'(pos_ext - CMP_W'(1));
                end
                ptr_nxt   = count_r;
                state_nxt = S_OPEN;
              end
            end
            ACT_DEL_POS: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                status_nxt = ST_BADPOS;
              end else begin
                idx_nxt   = IDX_W'(pos_ext - CMP_W'(1));
                ptr_nxt   = CNT_W'(pos_ext - CMP_W'(1));
                state_nxt = S_CLOSE;
              end
            end
            ACT_SEARCH: begin
              ptr_nxt   = '0;
              state_nxt = S_SEARCH;
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      // move entries up from the tail, one per cycle, then drop in the value
      S_OPEN: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_r;
          wr_data = rd_data_r;
        end
        if (ptr_r > CNT_W'(idx_r)) begin
          rd_en         = 1'b1;
          rd_addr       = IDX_W'(ptr_r - CNT_W'(1));
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt       = ptr_r - CNT_W'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = idx_r;
          wr_data   = value_r;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_DONE;
        end
      end
      // move entries down toward the hole
      S_CLOSE: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_r;
          wr_data = rd_data_r;
        end
        if (ptr_inc < count_r) begin
          rd_en         = 1'b1;
          rd_addr       = ptr_inc[IDX_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt       = ptr_inc;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end
      // read one entry per cycle, compare it the next
      S_SEARCH: begin
        if (pend_r && match) begin
          found_nxt  = LEN_W'(CNT_W'(pend_addr_r) + CNT_W'(1));
          status_nxt = ST_OK;
          pend_nxt   = 1'b0;
          state_nxt  = S_DONE;
        end else if (ptr_r < count_r) begin
          rd_en         = 1'b1;
          rd_addr       = ptr_r[IDX_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt       = ptr_inc;
        end else begin
          status_nxt = ST_NOTFOUND;
          pend_nxt   = 1'b0;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    idx_r       <= idx_nxt;
    pend_addr_r <= pend_addr_nxt;
    value_r     <= value_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign idle      = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_DONE);
  assign rsp.status         = status_r;
  assign rsp.found_position = found_r;
  assign rsp.length         = LEN_W'(count_r);

  `ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(CAPACITY))
  `ASSERT_IMPL(a_open_addr, (state_r == S_OPEN) && wr_en, CNT_W'(wr_addr) <= count_r)
  `ASSERT_IMPL(a_found_ok, rsp_valid && (found_r != '0), status_r == ST_OK)
  `ASSERT_NEXT(a_rsp_to_idle, rsp_valid && rsp_ready, idle)

endmodule

>>> hw/rtl/bounded_ordered_list_engine_unit.sv
`timescale 1ns / 1ps
// channel   dir  ports                          payload
// in_       in   in_tvalid/in_tready/in_tdata   action, value, position
// out_      out  out_tvalid/out_tready/out_tdata status, found_position, length
//
// one request at a time; in_tready is high only while the sequencer is idle, so the
// next request can be taken no earlier than the cycle after the result leaves the sequencer
// insert and delete move one entry per cycle through a ram with one read and one write port;
// search reads the entries in order and compares each one, stopping at the first match,
// so on a miss all of them are compared
// rejected or unknown actions go from idle straight to the done state; rst_n is synchronous
// a finished result sits in the output register while the next request is taken; the
// sequencer holds its result only while that register is full and out_tready is low

module bounded_ordered_list_engine_unit
  import bole_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // action[2:0], value[34:3], position[39:35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[2:0], found_position[7:3], length[12:8]
);

  req_t req;
  rsp_t rsp;
  logic core_idle, rsp_valid, rsp_ready;
  logic out_valid_r;
  rsp_t out_data_r;

  assign req.action   = in_tdata[2:0];
  assign req.value    = in_tdata[34:3];
  assign req.position = in_tdata[39:35];

  assign in_tready = core_idle;
  assign rsp_ready = !out_valid_r || out_tready;

  bole_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid && in_tready),
    .req       (req),
    .idle      (core_idle),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_ready (rsp_ready)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      out_data_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r.length, out_data_r.found_position,
                       out_data_r.status};

endmodule
